>>> design/orr_pkg.sv
package orr_pkg;

    localparam int FW        = 16;
    localparam int UNIT_ONE  = 16384;
    localparam int UNIT_SH   = 14;
    localparam int Q_W       = 15;
    localparam int NORM_TOP  = 30;
    localparam int MAG_W     = NORM_TOP + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int N2_W      = 64;
    localparam int S_W       = 32;
    localparam int NUM_W     = MAG_W + UNIT_SH + 1;
    localparam int ISQ_ITERS = S_W;
    localparam int ISQ_PER   = 2;
    localparam int ISQ_ST    = ISQ_ITERS / ISQ_PER;
    localparam int DIV_ITERS = Q_W;
    localparam int DIV_PER   = 2;
    localparam int DIV_ST    = (DIV_ITERS + DIV_PER - 1) / DIV_PER;
    // abs, max/lead-one, shift, square, sum, root stages, numerator, divide stages, sign
    localparam int NORM_LAT  = 5 + ISQ_ST + 1 + DIV_ST + 1;
    localparam int CROSS_LAT = 2;

    typedef struct packed {
        logic signed [FW-1:0] left_x;
        logic signed [FW-1:0] left_y;
        logic signed [FW-1:0] left_z;
        logic signed [FW-1:0] up_x;
        logic signed [FW-1:0] up_y;
        logic signed [FW-1:0] up_z;
    } t_in;

    typedef struct packed {
        logic signed [FW-1:0] row0_x;
        logic signed [FW-1:0] row0_y;
        logic signed [FW-1:0] row0_z;
        logic signed [FW-1:0] row1_x;
        logic signed [FW-1:0] row1_y;
        logic signed [FW-1:0] row1_z;
        logic signed [FW-1:0] row2_x;
        logic signed [FW-1:0] row2_y;
        logic signed [FW-1:0] row2_z;
        logic                 degenerate;
    } t_out;

    typedef struct packed {
        logic [N2_W-1:0]             n;
        logic [N2_W-1:0]             res;
        logic [2:0][MAG_W-1:0]       m;
        logic [2:0]                  neg;
        logic                        nz;
    } t_isq;

    typedef struct packed {
        logic [S_W-1:0] rem;
        logic [Q_W-1:0] nlo;
        logic [Q_W-1:0] q;
    } t_dvc;

    typedef struct packed {
        t_dvc [2:0]     c;
        logic [S_W-1:0] s;
        logic [2:0]     neg;
        logic           nz;
    } t_div;

    // one digit of the bit-pair square root; k is the iteration index from the top
    function automatic t_isq isq_step(input t_isq a, input int k);
        logic [N2_W-1:0] b;
        logic [N2_W-1:0] t;
        t_isq            r;
        begin
            r = a;
            b = N2_W'(1) << (N2_W - 2 - 2 * k);
            t = a.res + b;
            if (a.n >= t) begin
                r.n   = a.n - t;
                r.res = (a.res >> 1) + b;
            end else begin
                r.res = a.res >> 1;
            end
            return r;
        end
    endfunction

    // one restoring division step, quotient bit shifted in at the bottom
    function automatic t_dvc dvc_step(input t_dvc a, input logic [S_W-1:0] s);
        logic [S_W:0] t;
        logic [S_W:0] d;
        t_dvc         r;
        begin
            r     = a;
            t     = {a.rem, a.nlo[Q_W-1]};
            d     = t - {1'b0, s};
            r.nlo = a.nlo << 1;
            if (t >= {1'b0, s}) begin
                r.rem = d[S_W-1:0];
                r.q   = {a.q[Q_W-2:0], 1'b1};
            end else begin
                r.rem = t[S_W-1:0];
                r.q   = {a.q[Q_W-2:0], 1'b0};
            end
            return r;
        end
    endfunction

endpackage

>>> design/orthonormalize_rotation_rows_unit.sv
// Pipeline: three 31-stage normalizers, two 2-stage cross-product units and one
// output register.
// Throughput: one beat per cycle; the whole pipeline advances unless the output
// register holds a beat that is not taken.
// Reset (synchronous, active low) clears only the valid bits; data is not reset.
module orthonormalize_rotation_rows_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  orr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output orr_pkg::t_out o_out_data
);
    import orr_pkg::*;

    localparam int SW1 = 6 * FW;
    localparam int SW2 = 3 * FW + 1;
    localparam int SW3 = 6 * FW + 2;

    logic                 en;
    logic                 r_out_v;
    t_out                 r_out;
    t_out                 n_out;

    logic signed [FW-1:0] up_in [3];
    logic                 nu_v, c1_v, no_v, c2_v, nl_v;
    logic signed [FW-1:0] upn [3];
    logic signed [FW-1:0] outn [3];
    logic signed [FW-1:0] ln [3];
    logic                 nu_ok, no_ok, nl_ok;
    logic [SW1-1:0]       nu_sd;
    logic [SW2-1:0]       c1_sd, no_sd;
    logic [SW3-1:0]       c2_sd, nl_sd;
    logic signed [FW-1:0] lft [3];
    logic signed [FW-1:0] upr [3];
    logic signed [FW-1:0] upd [3];
    logic signed [2*FW:0] c1_vec [3];
    logic signed [2*FW:0] c2_vec [3];

    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en;

    assign up_in[0] = i_in_data.up_x;
    assign up_in[1] = i_in_data.up_y;
    assign up_in[2] = i_in_data.up_z;

    orr_norm #(.W(FW), .SW(SW1)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (i_in_valid),
        .i_vec   (up_in),
        .i_side  ({i_in_data.left_x, i_in_data.left_y, i_in_data.left_z,
                   i_in_data.up_x, i_in_data.up_y, i_in_data.up_z}),
        .o_v     (nu_v),
        .o_vec   (upn),
        .o_ok    (nu_ok),
        .o_side  (nu_sd)
    );

    assign lft[0] = nu_sd[6*FW-1:5*FW];
    assign lft[1] = nu_sd[5*FW-1:4*FW];
    assign lft[2] = nu_sd[4*FW-1:3*FW];
    assign upr[0] = nu_sd[3*FW-1:2*FW];
    assign upr[1] = nu_sd[2*FW-1:FW];
    assign upr[2] = nu_sd[FW-1:0];

    // out = left x up on the raw inputs
    orr_cross #(.W(FW), .SW(SW2)) u_cross_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (nu_v),
        .i_a     (lft),
        .i_b     (upr),
        .i_side  ({upn[0], upn[1], upn[2], nu_ok}),
        .o_v     (c1_v),
        .o_vec   (c1_vec),
        .o_side  (c1_sd)
    );

    orr_norm #(.W(2 * FW + 1), .SW(SW2)) u_norm_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (c1_v),
        .i_vec   (c1_vec),
        .i_side  (c1_sd),
        .o_v     (no_v),
        .o_vec   (outn),
        .o_ok    (no_ok),
        .o_side  (no_sd)
    );

    assign upd[0] = no_sd[3*FW:2*FW+1];
    assign upd[1] = no_sd[2*FW:FW+1];
    assign upd[2] = no_sd[FW:1];

    // rebuilt left = up_n x out_n
    orr_cross #(.W(FW), .SW(SW3)) u_cross_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (no_v),
        .i_a     (upd),
        .i_b     (outn),
        .i_side  ({no_sd[SW2-1:1], outn[0], outn[1], outn[2], no_sd[0], no_ok}),
        .o_v     (c2_v),
        .o_vec   (c2_vec),
        .o_side  (c2_sd)
    );

    orr_norm #(.W(2 * FW + 1), .SW(SW3)) u_norm_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (c2_v),
        .i_vec   (c2_vec),
        .i_side  (c2_sd),
        .o_v     (nl_v),
        .o_vec   (ln),
        .o_ok    (nl_ok),
        .o_side  (nl_sd)
    );

    always_comb begin
        n_out            = '0;
        n_out.degenerate = !(nl_sd[1] && nl_sd[0] && nl_ok);
        if (!n_out.degenerate) begin
            n_out.row0_x = ln[0];
            n_out.row0_y = ln[1];
            n_out.row0_z = ln[2];
            n_out.row1_x = nl_sd[6*FW+1:5*FW+2];
            n_out.row1_y = nl_sd[5*FW+1:4*FW+2];
            n_out.row1_z = nl_sd[4*FW+1:3*FW+2];
            n_out.row2_x = nl_sd[3*FW+1:2*FW+2];
            n_out.row2_y = nl_sd[2*FW+1:FW+2];
            n_out.row2_z = nl_sd[FW+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= nl_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

>>> design/orr_cross.sv
module orr_cross #(
    parameter int W  = 16,
    parameter int SW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_v,
    input  logic signed [W-1:0] i_a [3],
    input  logic signed [W-1:0] i_b [3],
    input  logic [SW-1:0]       i_side,
    output logic                o_v,
    output logic signed [2*W:0] o_vec [3],
    output logic [SW-1:0]       o_side
);
    import orr_pkg::*;

    logic signed [2*W-1:0] r_p [6];
    logic                  r_v [CROSS_LAT];
    logic [SW-1:0]         r_sd [CROSS_LAT];
    logic signed [2*W:0]   r_c [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_a[1] * i_b[2];
            r_p[1] <= i_a[2] * i_b[1];
            r_p[2] <= i_a[2] * i_b[0];
            r_p[3] <= i_a[0] * i_b[2];
            r_p[4] <= i_a[0] * i_b[1];
            r_p[5] <= i_a[1] * i_b[0];
            r_c[0] <= r_p[0] - r_p[1];
            r_c[1] <= r_p[2] - r_p[3];
            r_c[2] <= r_p[4] - r_p[5];
        end
    end

    for (genvar s = 0; s < CROSS_LAT; s++) begin : g_vs
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= i_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[s] <= i_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[s] <= r_sd[s-1];
                end
            end
        end
    end

    assign o_v    = r_v[CROSS_LAT-1];
    assign o_side = r_sd[CROSS_LAT-1];
    assign o_vec  = r_c;

endmodule

>>> design/orr_norm.sv
module orr_norm #(
    parameter int W  = 16,
    parameter int SW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_v,
    input  logic signed [W-1:0]         i_vec [3],
    input  logic [SW-1:0]               i_side,
    output logic                        o_v,
    output logic signed [orr_pkg::FW-1:0] o_vec [3],
    output logic                        o_ok,
    output logic [SW-1:0]               o_side
);
    import orr_pkg::*;

    localparam int HW = $clog2(W);
    localparam int XW = W + NORM_TOP;

    logic                 r_v  [NORM_LAT];
    logic [SW-1:0]        r_sd [NORM_LAT];

    logic [W-1:0]         r1_mag [3];
    logic [2:0]           r1_neg;
    logic [W-1:0]         r2_mag [3];
    logic [2:0]           r2_neg;
    logic [HW-1:0]        r2_h;
    logic                 r2_nz;
    logic [MAG_W-1:0]     r3_m [3];
    logic [2:0]           r3_neg;
    logic                 r3_nz;
    logic [SQ_W-1:0]      r4_sq [3];
    logic [MAG_W-1:0]     r4_m [3];
    logic [2:0]           r4_neg;
    logic                 r4_nz;
    t_isq                 r_iq [ISQ_ST+1];
    t_div                 r_dv [DIV_ST+1];
    logic signed [FW-1:0] r_fin [3];
    logic                 r_fin_nz;

    logic [W-1:0]         n_mag [3];
    logic [W-1:0]         n_mx;
    logic [HW-1:0]        n_h;
    logic [XW-1:0]        n_wide [3];
    t_isq                 n_iq0;
    t_div                 n_dv0;
    logic [NUM_W-1:0]     n_num [3];
    logic signed [FW-1:0] n_fin [3];

    // stage 0: magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
    end

    // stage 1: largest magnitude and its top set bit
    always_comb begin
        n_mx = r1_mag[0];
        if (r1_mag[1] > n_mx) n_mx = r1_mag[1];
        if (r1_mag[2] > n_mx) n_mx = r1_mag[2];
        n_h = '0;
        for (int i = 0; i < W; i++) begin
            if (n_mx[i]) n_h = HW'(i);
        end
    end

    // stage 2: bring the top bit to NORM_TOP, low bits dropped
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_wide[i] = (XW'(r2_mag[i]) << NORM_TOP) >> r2_h;
        end
    end

    always_comb begin
        n_iq0.n   = N2_W'(r4_sq[0]) + N2_W'(r4_sq[1]) + N2_W'(r4_sq[2]);
        n_iq0.res = '0;
        for (int i = 0; i < 3; i++) n_iq0.m[i] = r4_m[i];
        n_iq0.neg = r4_neg;
        n_iq0.nz  = r4_nz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n_mag;
            r1_neg   <= {i_vec[2][W-1], i_vec[1][W-1], i_vec[0][W-1]};
            r2_mag   <= r1_mag;
            r2_neg   <= r1_neg;
            r2_h     <= n_h;
            r2_nz    <= |n_mx;
            for (int i = 0; i < 3; i++) begin
                r3_m[i]  <= n_wide[i][MAG_W-1:0];
                r4_sq[i] <= r3_m[i] * r3_m[i];
            end
            r3_neg   <= r2_neg;
            r3_nz    <= r2_nz;
            r4_m     <= r3_m;
            r4_neg   <= r3_neg;
            r4_nz    <= r3_nz;
            r_iq[0]  <= n_iq0;
        end
    end

    for (genvar j = 1; j <= ISQ_ST; j++) begin : g_isq
        t_isq nx;
        always_comb begin
            nx = r_iq[j-1];
            for (int t = 0; t < ISQ_PER; t++) begin
                nx = isq_step(nx, ISQ_PER * (j - 1) + t);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_iq[j] <= nx;
            end
        end
    end

    // numerator mag * one + S/2, split into the part above the quotient and the low bits
    always_comb begin
        n_dv0.s   = r_iq[ISQ_ST].res[S_W-1:0];
        n_dv0.neg = r_iq[ISQ_ST].neg;
        n_dv0.nz  = r_iq[ISQ_ST].nz;
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NUM_W'(r_iq[ISQ_ST].m[i]) << UNIT_SH)
                     + NUM_W'(r_iq[ISQ_ST].res[S_W-1:1]);
            n_dv0.c[i].rem = S_W'(n_num[i][NUM_W-1:Q_W]);
            n_dv0.c[i].nlo = n_num[i][Q_W-1:0];
            n_dv0.c[i].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar j = 1; j <= DIV_ST; j++) begin : g_div
        t_div nx;
        always_comb begin
            nx = r_dv[j-1];
            for (int t = 0; t < DIV_PER; t++) begin
                if (DIV_PER * (j - 1) + t < DIV_ITERS) begin
                    for (int i = 0; i < 3; i++) begin
                        nx.c[i] = dvc_step(nx.c[i], nx.s);
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= nx;
            end
        end
    end

    always_comb begin
        logic [Q_W-1:0] q;
        logic [FW-1:0]  v;
        for (int i = 0; i < 3; i++) begin
            q = r_dv[DIV_ST].c[i].q;
            if (q > Q_W'(UNIT_ONE)) q = Q_W'(UNIT_ONE);
            v = {1'b0, q};
            n_fin[i] = r_dv[DIV_ST].neg[i] ? (~v + 1'b1) : v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin    <= n_fin;
            r_fin_nz <= r_dv[DIV_ST].nz;
        end
    end

    for (genvar s = 0; s < NORM_LAT; s++) begin : g_vs
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= i_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[s] <= i_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sd[s] <= r_sd[s-1];
                end
            end
        end
    end

    assign o_v    = r_v[NORM_LAT-1];
    assign o_side = r_sd[NORM_LAT-1];
    assign o_vec  = r_fin;
    assign o_ok   = r_fin_nz;

endmodule
